// ===== rtl/catl_pkg.sv =====
`timescale 1ns / 1ps
package catl_pkg;

   localparam int CHANNELS_DEF = 64;
   localparam int POINTS_DEF   = 128;

   localparam int FREQ_W  = 24;
   localparam int POWER_W = 16;
   localparam int STEP_W  = 11;
   localparam int MAX_W   = 8;
   localparam int CSR_W   = 11;

   // shared divider: signed dividend, unsigned divisor
   localparam int DIV_NW = 44;
   localparam int DIV_DW = 25;

   localparam logic [10:0] STEP_RESET = 11'd64;
   localparam logic [7:0]  MAX_RESET  = 8'd127;

   localparam logic CSR_ATTEN_STEP = 1'b0;
   localparam logic CSR_MAX_ATTEN  = 1'b1;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_EMPTY      = 3'd1;
   localparam logic [2:0] ST_POWER_HIGH = 3'd2;
   localparam logic [2:0] ST_BEYOND_MAX = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;

   localparam logic [4:0] OP_NONE       = 5'd0;
   localparam logic [4:0] OP_LOAD       = 5'd1;
   localparam logic [4:0] OP_CLEAR      = 5'd2;
   localparam logic [4:0] OP_INS_INIT   = 5'd3;
   localparam logic [4:0] OP_RD_PREV    = 5'd4;
   localparam logic [4:0] OP_SHIFT      = 5'd5;
   localparam logic [4:0] OP_INS_NEW    = 5'd6;
   localparam logic [4:0] OP_RD_FIRST   = 5'd7;
   localparam logic [4:0] OP_RD_LAST    = 5'd8;
   localparam logic [4:0] OP_GOT_LAST   = 5'd9;
   localparam logic [4:0] OP_RD_MID     = 5'd10;
   localparam logic [4:0] OP_MID_CMP    = 5'd11;
   localparam logic [4:0] OP_MUL        = 5'd12;
   localparam logic [4:0] OP_DIV_INTERP = 5'd13;
   localparam logic [4:0] OP_CAL_INTERP = 5'd14;
   localparam logic [4:0] OP_CAL_LO     = 5'd15;
   localparam logic [4:0] OP_CAL_HI     = 5'd16;
   localparam logic [4:0] OP_DIV_STEP   = 5'd17;
   localparam logic [4:0] OP_FINISH     = 5'd18;
   localparam logic [4:0] OP_FINISH_LK  = 5'd19;
   localparam logic [4:0] OP_INIT       = 5'd20;

   typedef struct packed {
      logic [4:0] op;
      logic [2:0] status;
   } cmd_type;

   typedef struct packed {
      logic       ch_valid;
      logic [1:0] req_kind;
      logic       count_zero;
      logic       full;
      logic       pos_zero;
      logic       prev_gt;
      logic       f_le_lo;
      logic       f_ge_hi;
      logic       gap_gt1;
      logic       flat;
      logic       div_done;
      logic       init_last;
   } sts_type;

endpackage

// ===== rtl/catl_ram.sv =====
`timescale 1ns / 1ps
module catl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/catl_div.sv =====
`timescale 1ns / 1ps
module catl_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [catl_pkg::DIV_NW-1:0]  num,
   input  logic [catl_pkg::DIV_DW-1:0]  den,
   output logic                         done,
   output logic [catl_pkg::DIV_NW-1:0]  quo
);
   import catl_pkg::*;
   localparam int CNTW = $clog2(DIV_NW);

   logic [DIV_NW-1:0] m_ff, m_in, q_ff, q_in;
   logic [DIV_DW-1:0] rem_ff, rem_in, d_ff, d_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic              neg_ff, neg_in, run_ff, run_in, done_ff, done_in;
   logic [DIV_DW:0]   trial, diff;
   logic              ge;

   // floor division: a negative dividend n is handled as -1 - (~n / d)
   always_comb begin
      trial   = {rem_ff, m_ff[DIV_NW-1]};
      ge      = trial >= {1'b0, d_ff};
      diff    = trial - {1'b0, d_ff};
      m_in    = m_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         neg_in = num[DIV_NW-1];
         m_in   = num[DIV_NW-1] ? ~num : num;
         d_in   = den;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
         m_in   = {m_ff[DIV_NW-2:0], 1'b0};
         q_in   = {q_ff[DIV_NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(DIV_NW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      m_ff   <= m_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? ~q_ff : q_ff;
endmodule

// ===== rtl/catl_dp.sv =====
`timescale 1ns / 1ps
module catl_dp #(
   parameter int CHANNELS = catl_pkg::CHANNELS_DEF,
   parameter int POINTS   = catl_pkg::POINTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [catl_pkg::CSR_W-1:0]   csr_wdata,
   input  logic [1:0]                   req_type,
   input  logic [5:0]                   req_channel,
   input  logic [23:0]                  req_frequency_khz,
   input  logic signed [15:0]           req_power_q8,
   input  catl_pkg::cmd_type            cmd,
   output catl_pkg::sts_type            sts,
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_status,
   output logic [7:0]                   rsp_atten_steps,
   output logic signed [15:0]           rsp_cal_power_q8,
   output logic [7:0]                   rsp_point_count
);
   import catl_pkg::*;
   localparam int CIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CDEPTH = (CHANNELS > 1) ? CHANNELS : 2;
   localparam int PIW    = $clog2(POINTS);
   localparam int CW     = $clog2(POINTS + 1);
   localparam int DEPTH  = CHANNELS * POINTS;
   localparam int AW     = $clog2(DEPTH);

   logic [1:0]          type_ff;
   logic [5:0]          ch_ff;
   logic [23:0]         f_ff;
   logic [15:0]         p_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [MAX_W-1:0]    max_ff;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CIW-1:0]      clr_ff, clr_in;
   logic                load_d_ff;
   logic [PIW-1:0]      pos_ff, pos_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [23:0]         lof_ff, lof_in, hif_ff, hif_in, den_ff, den_in;
   logic [15:0]         lop_ff, lop_in, hip_ff, hip_in, cal_ff, cal_in;
   logic signed [41:0]  prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_steps_ff, rsp_steps_in, rsp_count_ff, rsp_count_in;
   logic [15:0]         rsp_cal_ff, rsp_cal_in;

   logic [CIW-1:0]      ch_idx;
   logic                ch_valid;
   logic [CW-1:0]       cur_cnt, cnt_rd;
   logic [CIW-1:0]      cnt_raddr, cnt_waddr;
   logic                cnt_we;
   logic [PIW-1:0]      mid, rd_idx;
   logic [AW-1:0]       base, raddr, waddr;
   logic                we;
   logic [23:0]         rd_f, wr_f;
   logic [15:0]         rd_p, wr_p;
   logic signed [24:0]  df_s;
   logic signed [16:0]  dp_s;
   logic [10:0]         step_eff;
   logic [16:0]         diff_a;
   logic [18:0]         n2;
   logic [DIV_NW-1:0]   div_num, quo;
   logic [DIV_DW-1:0]   div_den;
   logic                div_go, div_done;

   assign ch_idx   = ch_ff[CIW-1:0];
   assign ch_valid = {1'b0, ch_ff} < 7'(CHANNELS);
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign base     = AW'(ch_idx) * AW'(POINTS);

   // point counts: read on the load cycle, then held in cnt_ff
   assign cnt_raddr = req_channel[CIW-1:0];
   assign cnt_waddr = (cmd.op == OP_INIT) ? clr_ff : ch_idx;
   assign cnt_we    = (cmd.op == OP_INIT) || (cmd.op == OP_CLEAR) || (cmd.op == OP_INS_NEW);
   assign cur_cnt   = load_d_ff ? cnt_rd : cnt_ff;

   catl_ram #(.WIDTH(CW), .DEPTH(CDEPTH)) u_count_ram (
      .clock(clock), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_in), .raddr(cnt_raddr),
      .rdata(cnt_rd)
   );

   always_comb begin
      case (cmd.op)
         OP_RD_PREV:  rd_idx = pos_ff - 1'b1;
         OP_RD_FIRST: rd_idx = '0;
         OP_RD_LAST:  rd_idx = PIW'(cur_cnt - 1'b1);
         OP_RD_MID:   rd_idx = mid;
         default:     rd_idx = pos_ff;
      endcase
   end

   assign raddr = base + AW'(rd_idx);
   assign waddr = base + AW'(pos_ff);
   assign we    = (cmd.op == OP_SHIFT) || (cmd.op == OP_INS_NEW);
   assign wr_f  = (cmd.op == OP_SHIFT) ? rd_f : f_ff;
   assign wr_p  = (cmd.op == OP_SHIFT) ? rd_p : p_ff;

   catl_ram #(.WIDTH(FREQ_W), .DEPTH(DEPTH)) u_freq_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wr_f), .raddr(raddr), .rdata(rd_f)
   );

   catl_ram #(.WIDTH(POWER_W), .DEPTH(DEPTH)) u_power_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wr_p), .raddr(raddr), .rdata(rd_p)
   );

   // interpolation and step rounding share one divider
   assign step_eff = (step_ff == '0) ? 11'd1 : step_ff;
   assign diff_a   = {cal_ff[15], cal_ff} - {p_ff[15], p_ff};
   assign n2       = {diff_a[16], diff_a, 1'b0} + {8'b0, step_eff};
   assign div_go   = (cmd.op == OP_DIV_INTERP) || (cmd.op == OP_DIV_STEP);
   assign div_num  = (cmd.op == OP_DIV_INTERP) ?
                     ({prod_ff[41], prod_ff, 1'b0} + {20'b0, den_ff}) :
                     {{25{n2[18]}}, n2};
   assign div_den  = (cmd.op == OP_DIV_INTERP) ? {den_ff, 1'b0} :
                     {13'b0, step_eff, 1'b0};

   catl_div u_div (
      .clock(clock), .reset(reset), .go(div_go), .num(div_num), .den(div_den),
      .done(div_done), .quo(quo)
   );

   assign df_s = $signed({1'b0, f_ff - lof_ff});
   assign dp_s = $signed({hip_ff[15], hip_ff}) - $signed({lop_ff[15], lop_ff});

   always_comb begin
      pos_in        = pos_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      lof_in        = lof_ff;
      lop_in        = lop_ff;
      hif_in        = hif_ff;
      hip_in        = hip_ff;
      prod_in       = prod_ff;
      den_in        = den_ff;
      cal_in        = cal_ff;
      cnt_in        = cur_cnt;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_steps_in  = rsp_steps_ff;
      rsp_cal_in    = rsp_cal_ff;
      rsp_count_in  = rsp_count_ff;
      case (cmd.op)
         OP_INIT: begin
            cnt_in = '0;
            clr_in = clr_ff + 1'b1;
         end
         OP_LOAD:     cal_in = '0;
         OP_CLEAR:    cnt_in = '0;
         OP_INS_NEW:  cnt_in = cur_cnt + 1'b1;
         OP_INS_INIT: pos_in = PIW'(cur_cnt);
         OP_SHIFT:    pos_in = pos_ff - 1'b1;
         OP_RD_LAST: begin
            lof_in = rd_f;
            lop_in = rd_p;
         end
         OP_GOT_LAST: begin
            hif_in = rd_f;
            hip_in = rd_p;
            lo_in  = '0;
            hi_in  = PIW'(cur_cnt - 1'b1);
         end
         OP_RD_MID:   pos_in = mid;
         OP_MID_CMP: begin
            if (rd_f <= f_ff) begin
               lo_in  = pos_ff;
               lof_in = rd_f;
               lop_in = rd_p;
            end else begin
               hi_in  = pos_ff;
               hif_in = rd_f;
               hip_in = rd_p;
            end
         end
         OP_MUL: begin
            prod_in = df_s * dp_s;
            den_in  = hif_ff - lof_ff;
         end
         OP_CAL_INTERP: cal_in = lop_ff + quo[15:0];
         OP_CAL_LO:     cal_in = lop_ff;
         OP_CAL_HI:     cal_in = hip_ff;
         OP_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = cmd.status;
            rsp_steps_in  = '0;
            rsp_cal_in    = cal_ff;
            rsp_count_in  = ch_valid ? 8'(cur_cnt) : 8'd0;
         end
         OP_FINISH_LK: begin
            rsp_valid_in = 1'b1;
            rsp_steps_in = '0;
            rsp_cal_in   = cal_ff;
            rsp_count_in = 8'(cur_cnt);
            if (quo[DIV_NW-1]) begin
               rsp_status_in = ST_POWER_HIGH;
            end else if (quo > {36'b0, max_ff}) begin
               rsp_status_in = ST_BEYOND_MAX;
            end else begin
               rsp_status_in = ST_OK;
               rsp_steps_in  = quo[7:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         max_ff       <= MAX_RESET;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         load_d_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         load_d_ff    <= cmd.op == OP_LOAD;
         if (csr_we) begin
            if (csr_index == CSR_ATTEN_STEP) begin
               step_ff <= csr_wdata[STEP_W-1:0];
            end else begin
               max_ff <= csr_wdata[MAX_W-1:0];
            end
         end
      end
      if (cmd.op == OP_LOAD) begin
         type_ff <= req_type;
         ch_ff   <= req_channel;
         f_ff    <= req_frequency_khz;
         p_ff    <= req_power_q8;
      end
      cnt_ff        <= cnt_in;
      pos_ff        <= pos_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      lof_ff        <= lof_in;
      lop_ff        <= lop_in;
      hif_ff        <= hif_in;
      hip_ff        <= hip_in;
      prod_ff       <= prod_in;
      den_ff        <= den_in;
      cal_ff        <= cal_in;
      rsp_status_ff <= rsp_status_in;
      rsp_steps_ff  <= rsp_steps_in;
      rsp_cal_ff    <= rsp_cal_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      sts.ch_valid   = ch_valid;
      sts.req_kind   = type_ff;
      sts.count_zero = cur_cnt == '0;
      sts.full       = cur_cnt == CW'(POINTS);
      sts.pos_zero   = pos_ff == '0;
      sts.prev_gt    = rd_f > f_ff;
      sts.f_le_lo    = f_ff <= lof_ff;
      sts.f_ge_hi    = f_ff >= hif_ff;
      sts.gap_gt1    = (hi_ff - lo_ff) > PIW'(1);
      sts.flat       = hif_ff == lof_ff;
      sts.div_done   = div_done;
      sts.init_last  = clr_ff == CIW'(CHANNELS - 1);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_atten_steps  = rsp_steps_ff;
   assign rsp_cal_power_q8 = rsp_cal_ff;
   assign rsp_point_count  = rsp_count_ff;
endmodule

// ===== rtl/catl_ctrl.sv =====
`timescale 1ns / 1ps
module catl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  catl_pkg::sts_type sts,
   output catl_pkg::cmd_type cmd
);
   import catl_pkg::*;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DECODE   = 5'd1;
   localparam logic [4:0] S_FIN      = 5'd2;
   localparam logic [4:0] S_INS_CHK  = 5'd3;
   localparam logic [4:0] S_INS_CMP  = 5'd4;
   localparam logic [4:0] S_INS_NEW  = 5'd5;
   localparam logic [4:0] S_LK_RD1   = 5'd6;
   localparam logic [4:0] S_LK_GOT   = 5'd7;
   localparam logic [4:0] S_LK_CLAMP = 5'd8;
   localparam logic [4:0] S_SRCH     = 5'd9;
   localparam logic [4:0] S_SRCH_CMP = 5'd10;
   localparam logic [4:0] S_INTERP   = 5'd11;
   localparam logic [4:0] S_DIV1     = 5'd12;
   localparam logic [4:0] S_WAIT1    = 5'd13;
   localparam logic [4:0] S_DIV2     = 5'd14;
   localparam logic [4:0] S_WAIT2    = 5'd15;
   localparam logic [4:0] S_INIT     = 5'd16;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      cmd.status = ST_OK;
      case (state_ff)
         S_INIT: begin
            cmd.op = OP_INIT;
            if (sts.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!sts.ch_valid) begin
               cmd.op     = OP_FINISH;
               cmd.status = ST_EMPTY;
               state_in   = S_IDLE;
            end else begin
               case (sts.req_kind)
                  REQ_CLEAR: begin
                     cmd.op   = OP_CLEAR;
                     state_in = S_FIN;
                  end
                  REQ_INSERT: begin
                     if (sts.full) begin
                        cmd.op     = OP_FINISH;
                        cmd.status = ST_FULL;
                        state_in   = S_IDLE;
                     end else begin
                        cmd.op   = OP_INS_INIT;
                        state_in = S_INS_CHK;
                     end
                  end
                  REQ_LOOKUP: begin
                     if (sts.count_zero) begin
                        cmd.op     = OP_FINISH;
                        cmd.status = ST_EMPTY;
                        state_in   = S_IDLE;
                     end else begin
                        cmd.op   = OP_RD_FIRST;
                        state_in = S_LK_RD1;
                     end
                  end
                  default: begin
                     cmd.op   = OP_FINISH;
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FIN: begin
            cmd.op   = OP_FINISH;
            state_in = S_IDLE;
         end
         S_INS_CHK: begin
            if (sts.pos_zero) begin
               state_in = S_INS_NEW;
            end else begin
               cmd.op   = OP_RD_PREV;
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (sts.prev_gt) begin
               cmd.op   = OP_SHIFT;
               state_in = S_INS_CHK;
            end else begin
               state_in = S_INS_NEW;
            end
         end
         S_INS_NEW: begin
            cmd.op   = OP_INS_NEW;
            state_in = S_FIN;
         end
         S_LK_RD1: begin
            cmd.op   = OP_RD_LAST;
            state_in = S_LK_GOT;
         end
         S_LK_GOT: begin
            cmd.op   = OP_GOT_LAST;
            state_in = S_LK_CLAMP;
         end
         S_LK_CLAMP: begin
            if (sts.f_le_lo) begin
               cmd.op   = OP_CAL_LO;
               state_in = S_DIV2;
            end else if (sts.f_ge_hi) begin
               cmd.op   = OP_CAL_HI;
               state_in = S_DIV2;
            end else begin
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (sts.gap_gt1) begin
               cmd.op   = OP_RD_MID;
               state_in = S_SRCH_CMP;
            end else begin
               state_in = S_INTERP;
            end
         end
         S_SRCH_CMP: begin
            cmd.op   = OP_MID_CMP;
            state_in = S_SRCH;
         end
         S_INTERP: begin
            if (sts.flat) begin
               cmd.op   = OP_CAL_LO;
               state_in = S_DIV2;
            end else begin
               cmd.op   = OP_MUL;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            cmd.op   = OP_DIV_INTERP;
            state_in = S_WAIT1;
         end
         S_WAIT1: begin
            if (sts.div_done) begin
               cmd.op   = OP_CAL_INTERP;
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            cmd.op   = OP_DIV_STEP;
            state_in = S_WAIT2;
         end
         S_WAIT2: begin
            if (sts.div_done) begin
               cmd.op   = OP_FINISH_LK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;
endmodule

// ===== rtl/calibrated_attenuation_lookup.sv =====
`timescale 1ns / 1ps
// per-channel sorted calibration tables with interpolated attenuation lookup
// request: present req_* with start high; a transfer happens when busy is low.
// busy stays high while the request is worked on; one result per request
// appears on rsp_* for exactly one cycle, flagged by rsp_valid.
// an insert shifts each larger point up one place until it meets a smaller or equal one;
// a lookup clamps to an end point or searches the table by halving, then interpolates.
// lookup time is set by passes through the shared 44-bit restoring divider: one for
// the step rounding, and one before it for the interpolation unless the lookup is
// clamped or the bracketing frequencies are equal.
// a new request is taken the cycle the result shows; one request at a time.
// the receiver cannot stall: rsp_valid is never held.
// csr_* writes take effect at once; the user must make them only while busy is low (not enforced).
// reset restores the step and max registers, then clears the point count of
// each channel in turn with busy high;
// the point memories are not cleared and are read only below the count.
module calibrated_attenuation_lookup #(
   parameter int CHANNELS = catl_pkg::CHANNELS_DEF,
   parameter int POINTS   = catl_pkg::POINTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_type,
   input  logic [5:0]                 req_channel,
   input  logic [23:0]                req_frequency_khz,
   input  logic signed [15:0]         req_power_q8,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic [7:0]                 rsp_atten_steps,
   output logic signed [15:0]         rsp_cal_power_q8,
   output logic [7:0]                 rsp_point_count,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [catl_pkg::CSR_W-1:0] csr_wdata
);
   import catl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   catl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
   );

   catl_dp #(.CHANNELS(CHANNELS), .POINTS(POINTS)) u_dp (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_type(req_type),
      .req_channel(req_channel),
      .req_frequency_khz(req_frequency_khz),
      .req_power_q8(req_power_q8),
      .cmd(cmd),
      .sts(sts),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_atten_steps(rsp_atten_steps),
      .rsp_cal_power_q8(rsp_cal_power_q8),
      .rsp_point_count(rsp_point_count)
   );
endmodule

// ===== sim/tb_calibrated_attenuation_lookup.sv =====
`timescale 1ns / 1ps
module tb_calibrated_attenuation_lookup;
   import catl_pkg::*;

   localparam logic [1:0] REQ_NOP = 2'd3;
   localparam int NCH = 64;
   localparam int NPT = 128;
   localparam int RANDOM_PER_PHASE = 300;

   typedef struct {
      logic [2:0]         status;
      logic [7:0]         steps;
      logic signed [15:0] cal;
      logic [7:0]         count;
   } atten_result_type;

   typedef struct {
      logic [1:0]         kind;
      logic [5:0]         ch;
      logic [23:0]        freq;
      logic signed [15:0] pwr;
      bit                 typed;
      atten_result_type   want;
   } directed_row_type;

   logic clock, reset, start, busy;
   logic [1:0] req_type;
   logic [5:0] req_channel;
   logic [23:0] req_frequency_khz;
   logic signed [15:0] req_power_q8;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [7:0] rsp_atten_steps;
   logic signed [15:0] rsp_cal_power_q8;
   logic [7:0] rsp_point_count;
   logic csr_we, csr_index;
   logic [CSR_W-1:0] csr_wdata;

   calibrated_attenuation_lookup dut (.*);

   // predictor state
   int unsigned cal_freq [NCH][NPT];
   int          cal_pwr  [NCH][NPT];
   int unsigned cal_count [NCH];
   int unsigned step_reg, max_reg;

   atten_result_type pending_results[$];
   int errors;
   int burst_left;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("calibrated_attenuation_lookup verification failed");
      $finish;
   end

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q -= 1;
      return q;
   endfunction

   function automatic int interp_power(int ch, int unsigned n, int unsigned f);
      int unsigned lo, hi, mid;
      longint num, den;
      if (f <= cal_freq[ch][0]) return cal_pwr[ch][0];
      if (f >= cal_freq[ch][n-1]) return cal_pwr[ch][n-1];
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
         mid = lo + (hi - lo) / 2;
         if (cal_freq[ch][mid] <= f) lo = mid;
         else hi = mid;
      end
      if (cal_freq[ch][hi] == cal_freq[ch][lo]) return cal_pwr[ch][lo];
      den = longint'(cal_freq[ch][hi]) - longint'(cal_freq[ch][lo]);
      num = (longint'(f) - longint'(cal_freq[ch][lo])) *
            (longint'(cal_pwr[ch][hi]) - longint'(cal_pwr[ch][lo]));
      return cal_pwr[ch][lo] + int'(floor_div(2 * num + den, 2 * den));
   endfunction

   function automatic atten_result_type predict_attenuation(logic [1:0] kind, int ch,
                                                            int unsigned f, int p);
      atten_result_type r;
      int unsigned pos;
      longint stp, a, s;
      int cal;
      r.status = ST_OK;
      r.steps = '0;
      r.cal = '0;
      case (kind)
         REQ_CLEAR: cal_count[ch] = 0;
         REQ_INSERT: begin
            if (cal_count[ch] >= NPT) r.status = ST_FULL;
            else begin
               pos = cal_count[ch];
               while (pos > 0 && cal_freq[ch][pos-1] > f) begin
                  cal_freq[ch][pos] = cal_freq[ch][pos-1];
                  cal_pwr[ch][pos] = cal_pwr[ch][pos-1];
                  pos--;
               end
               cal_freq[ch][pos] = f;
               cal_pwr[ch][pos] = p;
               cal_count[ch]++;
            end
         end
         REQ_LOOKUP: begin
            if (cal_count[ch] == 0) r.status = ST_EMPTY;
            else begin
               stp = (step_reg == 0) ? 1 : step_reg;
               cal = interp_power(ch, cal_count[ch], f);
               a = longint'(cal) - longint'(p);
               s = floor_div(2 * a + stp, 2 * stp);
               r.cal = cal[15:0];
               if (s < 0) r.status = ST_POWER_HIGH;
               else if (s > max_reg) r.status = ST_BEYOND_MAX;
               else r.steps = s[7:0];
            end
         end
         default: ;
      endcase
      r.count = cal_count[ch][7:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      atten_result_type w;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) report_mismatch("unexpected result", 1, 0);
         else begin
            w = pending_results.pop_front();
            if (rsp_status !== w.status) report_mismatch("status", rsp_status, w.status);
            if (rsp_atten_steps !== w.steps)
               report_mismatch("atten_steps", rsp_atten_steps, w.steps);
            if (rsp_cal_power_q8 !== w.cal)
               report_mismatch("cal_power", rsp_cal_power_q8, w.cal);
            if (rsp_point_count !== w.count)
               report_mismatch("point_count", rsp_point_count, w.count);
         end
      end
   end

   task automatic send_request(logic [1:0] kind, logic [5:0] ch, logic [23:0] f,
                               logic signed [15:0] p, bit typed, atten_result_type want);
      atten_result_type r;
      int gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
         @(negedge clock);
         if (gap > 0) begin
            start = 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end else @(negedge clock);
      burst_left--;
      start = 1;
      req_type = kind;
      req_channel = ch;
      req_frequency_khz = f;
      req_power_q8 = p;
      do @(posedge clock); while (busy);
      r = predict_attenuation(kind, ch, f, p);
      pending_results.push_back(typed ? want : r);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int unsigned value);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = value[CSR_W-1:0];
      @(negedge clock);
      csr_we = 0;
      if (idx == CSR_ATTEN_STEP) step_reg = value & 32'h7FF;
      else max_reg = value & 32'hFF;
   endtask

   function automatic logic signed [15:0] clamp16(int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   task automatic random_request();
      atten_result_type none;
      int ch, pick, k, idx;
      logic [1:0] kind;
      logic [23:0] f;
      logic signed [15:0] p;
      none = '{default: '0};
      ch = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, NCH - 1);
      pick = $urandom_range(0, 99);
      kind = (pick < 42) ? REQ_INSERT : (pick < 90) ? REQ_LOOKUP :
             (pick < 95) ? REQ_CLEAR : REQ_NOP;
      k = $urandom_range(0, 9);
      if (k < 3) f = 24'($urandom_range(0, 24'hFFFFFF));
      else if (k < 5 && cal_count[ch] > 0)
         f = 24'(cal_freq[ch][$urandom_range(0, cal_count[ch]-1)]);
      else f = 24'($urandom_range(0, 100000));
      if (kind == REQ_LOOKUP && cal_count[ch] > 0 && $urandom_range(0, 9) < 8) begin
         idx = $urandom_range(0, cal_count[ch] - 1);
         p = clamp16(cal_pwr[ch][idx] - int'($urandom_range(0, 300)) *
                     ((step_reg == 0) ? 1 : int'(step_reg)) + int'($urandom_range(0, 80)) - 40);
      end else if ($urandom_range(0, 9) < 4) p = 16'($urandom_range(0, 16'hFFFF));
      else p = clamp16(int'($urandom_range(0, 10000)) - 5000);
      send_request(kind, 6'(ch), f, p, 0, none);
   endtask

   directed_row_type directed[] = '{
      '{REQ_LOOKUP, 6'd0, 24'd1000, 16'sd0, 1, '{ST_EMPTY, 8'd0, 16'sd0, 8'd0}},
      '{REQ_CLEAR, 6'd0, 24'd0, 16'sd0, 1, '{ST_OK, 8'd0, 16'sd0, 8'd0}},
      '{REQ_INSERT, 6'd0, 24'd1000, 16'sd0, 1, '{ST_OK, 8'd0, 16'sd0, 8'd1}},
      '{REQ_INSERT, 6'd0, 24'd3000, 16'sd512, 1, '{ST_OK, 8'd0, 16'sd0, 8'd2}},
      '{REQ_INSERT, 6'd0, 24'd2000, 16'sd256, 1, '{ST_OK, 8'd0, 16'sd0, 8'd3}},
      '{REQ_INSERT, 6'd0, 24'd2000, 16'sd100, 1, '{ST_OK, 8'd0, 16'sd0, 8'd4}},
      '{REQ_LOOKUP, 6'd0, 24'd0, 16'sd0, 1, '{ST_OK, 8'd0, 16'sd0, 8'd4}},
      '{REQ_LOOKUP, 6'd0, 24'hFFFFFF, -16'sd32768, 0, '{ST_OK, 8'd0, 16'sd0, 8'd0}},
      '{REQ_LOOKUP, 6'd0, 24'd2000, 16'sd0, 0, '{ST_OK, 8'd0, 16'sd0, 8'd0}},
      '{REQ_LOOKUP, 6'd0, 24'd2500, 16'sd0, 0, '{ST_OK, 8'd0, 16'sd0, 8'd0}},
      '{REQ_LOOKUP, 6'd0, 24'd1500, 16'sd100, 0, '{ST_OK, 8'd0, 16'sd0, 8'd0}},
      '{REQ_LOOKUP, 6'd0, 24'd2700, 16'sd32767, 0, '{ST_OK, 8'd0, 16'sd0, 8'd0}},
      '{REQ_NOP, 6'd0, 24'hFFFFFF, -16'sd1, 1, '{ST_OK, 8'd0, 16'sd0, 8'd4}},
      '{REQ_INSERT, 6'd63, 24'hFFFFFF, 16'sd32767, 1, '{ST_OK, 8'd0, 16'sd0, 8'd1}},
      '{REQ_INSERT, 6'd63, 24'd0, -16'sd32768, 1, '{ST_OK, 8'd0, 16'sd0, 8'd2}},
      '{REQ_LOOKUP, 6'd63, 24'h800000, -16'sd32768, 0, '{ST_OK, 8'd0, 16'sd0, 8'd0}},
      '{REQ_LOOKUP, 6'd63, 24'hFFFFFF, 16'sd32767, 1, '{ST_OK, 8'd0, 16'sd32767, 8'd2}},
      '{REQ_NOP, 6'd63, 24'd0, 16'sd0, 1, '{ST_OK, 8'd0, 16'sd0, 8'd2}},
      '{REQ_CLEAR, 6'd0, 24'd0, 16'sd0, 1, '{ST_OK, 8'd0, 16'sd0, 8'd0}},
      '{REQ_LOOKUP, 6'd0, 24'd2000, 16'sd0, 1, '{ST_EMPTY, 8'd0, 16'sd0, 8'd0}}
   };

   int unsigned phase_step [5] = '{1, 1024, 0, 37, 64};
   int unsigned phase_max  [5] = '{255, 0, 200, 50, 127};

   initial begin
      atten_result_type none;
      none = '{default: '0};
      errors = 0;
      burst_left = 0;
      step_reg = 64;
      max_reg = 127;
      foreach (cal_count[i]) cal_count[i] = 0;
      reset = 1;
      start = 0;
      req_type = REQ_CLEAR;
      req_channel = '0;
      req_frequency_khz = '0;
      req_power_q8 = '0;
      csr_we = 0;
      csr_index = CSR_ATTEN_STEP;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (directed[i])
         send_request(directed[i].kind, directed[i].ch, directed[i].freq,
                      directed[i].pwr, directed[i].typed, directed[i].want);

      for (int ph = 0; ph < 5; ph++) begin
         drain_results();
         write_csr(CSR_ATTEN_STEP, phase_step[ph]);
         write_csr(CSR_MAX_ATTEN, phase_max[ph]);
         if (ph == 1) begin
            // fill one table past its capacity
            send_request(REQ_CLEAR, 6'd9, 24'd0, 16'sd0, 0, none);
            for (int n = 0; n < NPT + 2; n++)
               send_request(REQ_INSERT, 6'd9, 24'($urandom_range(0, 24'hFFFFFF)),
                            16'($urandom_range(0, 16'hFFFF)), 0, none);
            for (int n = 0; n < 6; n++)
               send_request(REQ_LOOKUP, 6'd9, 24'($urandom_range(0, 24'hFFFFFF)),
                            16'($urandom_range(0, 16'hFFFF)), 0, none);
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) random_request();
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("calibrated_attenuation_lookup verification clean");
      else
         $display("calibrated_attenuation_lookup verification failed");
      $finish;
   end

endmodule
